### design/bpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer page table package
// Sizes, link coding, transaction structs and the bucket hash shared by the
// page table sequencer, its storage and the top level.
// ----------------------------------------------------------------------------
package bpt_pkg;

   // table geometry
   localparam int BUCKETS    = 1024;
   localparam int BUFFERS    = 1024;
   localparam int HASH_SHIFT = 22;

   // fixed field widths
   localparam int FILE_W   = 16;
   localparam int PAGE_W   = 32;
   localparam int BUF_ID_W = 10;

   // derived widths
   localparam int BUCKET_W  = $clog2(BUCKETS);
   localparam int BUF_W     = $clog2(BUFFERS);
   localparam int LINK_W    = $clog2(BUFFERS + 1);
   localparam int KEY_SUM_W = FILE_W + HASH_SHIFT + 1;
   localparam int CLEAR_LEN = (BUCKETS > BUFFERS) ? BUCKETS : BUFFERS;
   localparam int CLR_W     = $clog2(CLEAR_LEN);

   // empty chain link
   localparam logic [LINK_W-1:0] NIL = LINK_W'(BUFFERS);

   // operation codes
   localparam logic OP_FIND  = 1'b0;
   localparam logic OP_REMAP = 1'b1;

   // status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_REFUSED = 1'b1;

   typedef struct packed {
      logic                op;
      logic [FILE_W-1:0]   key_file_id;
      logic [PAGE_W-1:0]   key_page_num;
      logic [FILE_W-1:0]   old_file_id;
      logic [PAGE_W-1:0]   old_page_num;
      logic [BUF_ID_W-1:0] buffer_id;
   } bpt_req_type;

   typedef struct packed {
      logic                hit;
      logic [BUF_ID_W-1:0] found_buffer;
      logic                status;
   } bpt_rsp_type;

   typedef struct packed {
      logic                head_re;
      logic [BUCKET_W-1:0] head_raddr;
      logic                head_we;
      logic [BUCKET_W-1:0] head_waddr;
      logic [LINK_W-1:0]   head_wdata;
      logic                ent_re;
      logic [BUF_W-1:0]    ent_raddr;
      logic                key_we;
      logic [BUF_W-1:0]    key_waddr;
      logic [FILE_W-1:0]   key_wfile;
      logic [PAGE_W-1:0]   key_wpage;
      logic                next_we;
      logic [BUF_W-1:0]    next_waddr;
      logic [LINK_W-1:0]   next_wdata;
      logic                live_re;
      logic [BUF_W-1:0]    live_raddr;
      logic                live_we;
      logic [BUF_W-1:0]    live_waddr;
      logic                live_wdata;
   } bpt_mem_cmd_type;

   typedef struct packed {
      logic [LINK_W-1:0] head_q;
      logic [FILE_W-1:0] file_q;
      logic [PAGE_W-1:0] page_q;
      logic [LINK_W-1:0] next_q;
      logic              live_q;
      logic              ready;
   } bpt_mem_rsp_type;

   // bucket of a key: ((file << 22) + page) mod BUCKETS, BUCKETS a power of two
   function automatic logic [BUCKET_W-1:0] bucket_of(input logic [FILE_W-1:0] file,
                                                     input logic [PAGE_W-1:0] page);
      logic [KEY_SUM_W-1:0] sum;
      sum = (KEY_SUM_W'(file) << HASH_SHIFT) + KEY_SUM_W'(page);
      return BUCKET_W'(sum % KEY_SUM_W'(BUCKETS));
   endfunction

endpackage
`default_nettype wire

### design/bpt_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer page table storage
// Chain heads, entry keys, entry links and live flags, each a one-write,
// one-read memory with registered read data; clears heads and live flags
// in a sweep after reset.
// ----------------------------------------------------------------------------
module bpt_store
   import bpt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  bpt_mem_cmd_type cmd,
   output bpt_mem_rsp_type rsp
);

   logic [LINK_W-1:0] head_mem [BUCKETS];
   logic [FILE_W-1:0] file_mem [BUFFERS];
   logic [PAGE_W-1:0] page_mem [BUFFERS];
   logic [LINK_W-1:0] next_mem [BUFFERS];
   logic              live_mem [BUFFERS];

   logic [LINK_W-1:0] head_q_ff;
   logic [FILE_W-1:0] file_q_ff;
   logic [PAGE_W-1:0] page_q_ff;
   logic [LINK_W-1:0] next_q_ff;
   logic              live_q_ff;

   logic              clearing_ff, clearing_in;
   logic [CLR_W-1:0]  clr_idx_ff, clr_idx_in;

   logic                head_we;
   logic [BUCKET_W-1:0] head_waddr;
   logic [LINK_W-1:0]   head_wdata;
   logic                live_we;
   logic [BUF_W-1:0]    live_waddr;
   logic                live_wdata;

   // sweep control
   always_comb begin
      clearing_in = clearing_ff;
      clr_idx_in  = clr_idx_ff;
      if (clearing_ff) begin
         clr_idx_in = clr_idx_ff + CLR_W'(1);
         if (clr_idx_ff == CLR_W'(CLEAR_LEN - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   // sweep takes over the head and live write ports
   always_comb begin
      head_we    = cmd.head_we;
      head_waddr = cmd.head_waddr;
      head_wdata = cmd.head_wdata;
      live_we    = cmd.live_we;
      live_waddr = cmd.live_waddr;
      live_wdata = cmd.live_wdata;
      if (clearing_ff) begin
         head_we    = ({1'b0, clr_idx_ff} < (CLR_W + 1)'(BUCKETS));
         head_waddr = clr_idx_ff[BUCKET_W-1:0];
         head_wdata = NIL;
         live_we    = ({1'b0, clr_idx_ff} < (CLR_W + 1)'(BUFFERS));
         live_waddr = clr_idx_ff[BUF_W-1:0];
         live_wdata = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[head_waddr] <= head_wdata;
      end
      if (cmd.head_re) begin
         head_q_ff <= head_mem[cmd.head_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.key_we) begin
         file_mem[cmd.key_waddr] <= cmd.key_wfile;
         page_mem[cmd.key_waddr] <= cmd.key_wpage;
      end
      if (cmd.ent_re) begin
         file_q_ff <= file_mem[cmd.ent_raddr];
         page_q_ff <= page_mem[cmd.ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.next_we) begin
         next_mem[cmd.next_waddr] <= cmd.next_wdata;
      end
      if (cmd.ent_re) begin
         next_q_ff <= next_mem[cmd.ent_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (live_we) begin
         live_mem[live_waddr] <= live_wdata;
      end
      if (cmd.live_re) begin
         live_q_ff <= live_mem[cmd.live_raddr];
      end
   end

   assign rsp.head_q = head_q_ff;
   assign rsp.file_q = file_q_ff;
   assign rsp.page_q = page_q_ff;
   assign rsp.next_q = next_q_ff;
   assign rsp.live_q = live_q_ff;
   assign rsp.ready  = !clearing_ff;

endmodule
`default_nettype wire

### design/bpt_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer page table sequencer
// Walks a hash chain one entry per cycle through the shared key compare,
// then decides, unlinks and pushes for a remap.
// ----------------------------------------------------------------------------
module bpt_seq
   import bpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpt_req_type       req_data,
   input  logic [PAGE_W-1:0] invalid_page_code,
   output logic              rsp_valid,
   output bpt_rsp_type       rsp_data,
   output bpt_mem_cmd_type   mem_cmd,
   input  bpt_mem_rsp_type   mem_rsp
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_HEAD,
      S_CMP,
      S_DECIDE,
      S_PUSH_RD,
      S_PUSH_WR
   } state_type;

   state_type         state_ff, state_in;
   bpt_req_type       req_ff, req_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [LINK_W-1:0] next_e_ff, next_e_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bpt_rsp_type       rsp_ff, rsp_in;

   logic [FILE_W-1:0]   walk_file;
   logic [PAGE_W-1:0]   walk_page;
   logic                key_match;
   logic [LINK_W-1:0]   steps_inc;
   logic                bid_bad;
   logic                no_old;
   logic [BUF_W-1:0]    bid;
   logic [BUCKET_W-1:0] new_bucket;

   // chain being walked: key for a find, old key for a remap
   assign walk_file  = (req_ff.op == OP_FIND) ? req_ff.key_file_id  : req_ff.old_file_id;
   assign walk_page  = (req_ff.op == OP_FIND) ? req_ff.key_page_num : req_ff.old_page_num;
   assign key_match  = (mem_rsp.file_q == walk_file) && (mem_rsp.page_q == walk_page);
   assign steps_inc  = steps_ff + LINK_W'(1);
   assign bid_bad    = (32'(req_ff.buffer_id) >= 32'(BUFFERS));
   assign no_old     = (req_data.old_file_id == '0) &&
                       (req_data.old_page_num == invalid_page_code);
   assign bid        = BUF_W'(req_ff.buffer_id);
   assign new_bucket = bucket_of(req_ff.key_file_id, req_ff.key_page_num);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      prev_in      = prev_ff;
      steps_in     = steps_ff;
      next_e_in    = next_e_ff;
      found_in     = found_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      mem_cmd      = '0;
      case (state_ff)
         S_CLEAR: begin
            if (mem_rsp.ready) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               req_in             = req_data;
               found_in           = 1'b0;
               mem_cmd.live_re    = 1'b1;
               mem_cmd.live_raddr = BUF_W'(req_data.buffer_id);
               if (req_data.op == OP_FIND) begin
                  mem_cmd.head_re    = 1'b1;
                  mem_cmd.head_raddr = bucket_of(req_data.key_file_id,
                                                 req_data.key_page_num);
                  state_in           = S_HEAD;
               end else if ((32'(req_data.buffer_id) >= 32'(BUFFERS)) || no_old) begin
                  state_in = S_DECIDE;
               end else begin
                  mem_cmd.head_re    = 1'b1;
                  mem_cmd.head_raddr = bucket_of(req_data.old_file_id,
                                                 req_data.old_page_num);
                  state_in           = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            if (mem_rsp.head_q >= NIL) begin
               state_in = S_DECIDE;
            end else begin
               cur_in            = mem_rsp.head_q;
               prev_in           = NIL;
               steps_in          = '0;
               mem_cmd.ent_re    = 1'b1;
               mem_cmd.ent_raddr = mem_rsp.head_q[BUF_W-1:0];
               state_in          = S_CMP;
            end
         end
         S_CMP: begin
            if (key_match) begin
               found_in  = 1'b1;
               next_e_in = mem_rsp.next_q;
               state_in  = S_DECIDE;
            end else begin
               prev_in  = cur_ff;
               cur_in   = mem_rsp.next_q;
               steps_in = steps_inc;
               if ((mem_rsp.next_q >= NIL) || (steps_inc == LINK_W'(BUFFERS))) begin
                  state_in = S_DECIDE;
               end else begin
                  mem_cmd.ent_re    = 1'b1;
                  mem_cmd.ent_raddr = mem_rsp.next_q[BUF_W-1:0];
               end
            end
         end
         S_DECIDE: begin
            rsp_in.hit          = 1'b0;
            rsp_in.found_buffer = '0;
            rsp_in.status       = STATUS_OK;
            if (req_ff.op == OP_REMAP) begin
               if (bid_bad) begin
                  rsp_in.status = STATUS_REFUSED;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else if (found_ff && (cur_ff[BUF_W-1:0] != bid)) begin
                  // old key belongs to another buffer
                  rsp_in.status       = STATUS_REFUSED;
                  rsp_in.found_buffer = BUF_ID_W'(cur_ff[BUF_W-1:0]);
                  rsp_valid_in        = 1'b1;
                  state_in            = S_IDLE;
               end else if (!found_ff && mem_rsp.live_q) begin
                  // buffer would end up holding two pages
                  rsp_in.status = STATUS_REFUSED;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_IDLE;
               end else begin
                  if (found_ff) begin
                     if (prev_ff < NIL) begin
                        mem_cmd.next_we    = 1'b1;
                        mem_cmd.next_waddr = prev_ff[BUF_W-1:0];
                        mem_cmd.next_wdata = next_e_ff;
                     end else begin
                        mem_cmd.head_we    = 1'b1;
                        mem_cmd.head_waddr = bucket_of(req_ff.old_file_id,
                                                       req_ff.old_page_num);
                        mem_cmd.head_wdata = next_e_ff;
                     end
                  end
                  state_in = S_PUSH_RD;
               end
            end else begin
               rsp_in.hit          = found_ff;
               rsp_in.found_buffer = found_ff ? BUF_ID_W'(cur_ff[BUF_W-1:0]) : '0;
               rsp_valid_in        = 1'b1;
               state_in            = S_IDLE;
            end
         end
         S_PUSH_RD: begin
            mem_cmd.head_re    = 1'b1;
            mem_cmd.head_raddr = new_bucket;
            state_in           = S_PUSH_WR;
         end
         S_PUSH_WR: begin
            mem_cmd.key_we      = 1'b1;
            mem_cmd.key_waddr   = bid;
            mem_cmd.key_wfile   = req_ff.key_file_id;
            mem_cmd.key_wpage   = req_ff.key_page_num;
            mem_cmd.next_we     = 1'b1;
            mem_cmd.next_waddr  = bid;
            mem_cmd.next_wdata  = mem_rsp.head_q;
            mem_cmd.head_we     = 1'b1;
            mem_cmd.head_waddr  = new_bucket;
            mem_cmd.head_wdata  = LINK_W'(bid);
            mem_cmd.live_we     = 1'b1;
            mem_cmd.live_waddr  = bid;
            mem_cmd.live_wdata  = 1'b1;
            rsp_in.hit          = found_ff;
            rsp_in.found_buffer = found_ff ? req_ff.buffer_id : '0;
            rsp_in.status       = STATUS_OK;
            rsp_valid_in        = 1'b1;
            state_in            = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      cur_ff    <= cur_in;
      prev_ff   <= prev_in;
      steps_ff  <= steps_in;
      next_e_ff <= next_e_in;
      found_ff  <= found_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

### design/buffer_page_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer page table
// Maps (file id, page number) to a buffer id through chained hash buckets.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req_data; the transaction is taken on an
//   edge where start is high and busy is low. op selects a find of the key or
//   a remap of buffer_id from the old key to the key.
//   Each transaction returns one response on rsp_data, shown for exactly one
//   cycle with rsp_valid high. The receiver cannot stall; the response sits
//   in an output register, and busy is already low on that cycle so the
//   next transaction may start right away.
//   A find holds busy while it reads the chain head, compares the chain
//   entries in turn and decides; a successful remap then also reads and
//   rewrites the new chain head. A remap with no old page skips the walk
//   and goes straight to the decision; a refused remap ends at the decision.
//   The chain walk, one entry read per cycle from the entry memory, sets
//   how long busy stays high.
//   After reset the block sweeps the bucket heads and live flags, one entry a
//   cycle, with busy high. csr_we writes invalid_page_code at any time;
//   change it only while no transaction is in flight.
// ----------------------------------------------------------------------------
module buffer_page_table
   import bpt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bpt_req_type       req_data,
   output logic              rsp_valid,
   output bpt_rsp_type       rsp_data,
   input  logic              csr_we,
   input  logic [PAGE_W-1:0] csr_wdata
);

   // page code that, paired with file 0, marks "no old page" on a remap
   logic [PAGE_W-1:0] invalid_page_code_ff, invalid_page_code_in;

   bpt_mem_cmd_type mem_cmd;
   bpt_mem_rsp_type mem_rsp;

   // hold the register unless written
   assign invalid_page_code_in = csr_we ? csr_wdata : invalid_page_code_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         invalid_page_code_ff <= '1;
      end else begin
         invalid_page_code_ff <= invalid_page_code_in;
      end
   end

   // sequencer: chain walk, decision, unlink and push
   bpt_seq u_seq (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_data          (req_data),
      .invalid_page_code (invalid_page_code_ff),
      .rsp_valid         (rsp_valid),
      .rsp_data          (rsp_data),
      .mem_cmd           (mem_cmd),
      .mem_rsp           (mem_rsp)
   );

   // storage: heads, keys, links, live flags and the reset sweep
   bpt_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (mem_cmd),
      .rsp   (mem_rsp)
   );

   // the block comes out of reset sweeping, so it must not take work
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // a response only appears once its transaction has released the block
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !busy)
      else $error("response shown while still busy");

   // no transaction answers on the cycle right after it is taken
   assert property (@(posedge clock) disable iff (reset) (start && !busy) |=> !rsp_valid)
      else $error("response one cycle after accept");

   // a refused remap never claims a hit
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid && (rsp_data.status == STATUS_REFUSED)) |-> !rsp_data.hit)
      else $error("refused response with hit set");

endmodule
`default_nettype wire

### test/buffer_page_table_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Buffer page table testbench
// Sends finds and remaps through the start/busy port and predicts every reply
// with a behavioral copy of the chained hash table. Replies are compared in
// order, field by field. A directed part covers empty lookups, duplicate keys,
// unlinks mid-chain and at the tail, refused remaps and the no-old-page code.
// Random traffic follows under several settings of invalid_page_code.
// ----------------------------------------------------------------------------
module buffer_page_table_test;
   import bpt_pkg::*;

   localparam int CLK_HALF     = 5;
   localparam int RESET_CYCLES = 11;
   // A reply may need a walk of up to BUFFERS entries plus the longest sender
   // gap; the limit covers that for every transaction, several times over.
   localparam int LIMIT_CYCLES = 10_000_000;
   localparam int TAIL_CYCLES  = 40;
   localparam int IDLE_SETTLE  = 4;
   localparam int HOT_COUNT    = 16;
   localparam logic [PAGE_W-1:0] NO_PAGE_AT_RESET = '1;

   // ways to spoil a remap in the noise part of the random traffic
   typedef enum int unsigned {
      SPOIL_OTHER_OWNER,
      SPOIL_RANDOM_OLD,
      SPOIL_NO_PAGE,
      SPOIL_FLIPPED_OLD
   } spoil_kind_type;

   // ---------------------------------------------------------------------
   // DUT ports; every input holds a known value from time zero
   // ---------------------------------------------------------------------
   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              start     = 1'b0;
   bpt_req_type       req_data  = '0;
   logic              csr_we    = 1'b0;
   logic [PAGE_W-1:0] csr_wdata = '0;
   logic              busy;
   logic              rsp_valid;
   bpt_rsp_type       rsp_data;

   buffer_page_table u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #CLK_HALF clock = ~clock;

   // ---------------------------------------------------------------------
   // Behavioral page table: chain heads, one slot per buffer, and the
   // current no-old-page code. The empty link is NIL, as in the block.
   // ---------------------------------------------------------------------
   logic [LINK_W-1:0] chain_head  [BUCKETS];
   logic [FILE_W-1:0] slot_file   [BUFFERS];
   logic [PAGE_W-1:0] slot_page   [BUFFERS];
   logic [LINK_W-1:0] slot_next   [BUFFERS];
   logic              slot_mapped [BUFFERS];
   logic [PAGE_W-1:0] no_page_code;

   // predicted replies, oldest first
   bpt_rsp_type lookup_results_q [$];

   int error_count = 0;
   int cycle_count = 0;

   // buckets that most random pages fall into, so chains grow long
   logic [BUCKET_W-1:0] hot_bucket [HOT_COUNT];
   // no sender gaps while set
   bit burst_mode = 1'b0;

   task automatic clear_table_model();
      for (int i = 0; i < BUCKETS; i++) chain_head[i] = NIL;
      for (int i = 0; i < BUFFERS; i++) begin
         slot_file[i]   = '0;
         slot_page[i]   = '0;
         slot_next[i]   = '0;
         slot_mapped[i] = 1'b0;
      end
      no_page_code = NO_PAGE_AT_RESET;
   endtask

   // bucket of a key, with the sum taken in 64 bits
   function automatic int unsigned bucket_index(input logic [FILE_W-1:0] f,
                                                input logic [PAGE_W-1:0] p);
      logic [63:0] sum;
      sum = (64'(f) << HASH_SHIFT) + 64'(p);
      return 32'(sum % 64'(BUCKETS));
   endfunction

   // Walk the chain of a key; return the first matching slot or NIL, and
   // its predecessor through pred. Give up after BUFFERS steps.
   function automatic logic [LINK_W-1:0] chain_search(input logic [FILE_W-1:0] f,
                                                      input logic [PAGE_W-1:0] p,
                                                      output logic [LINK_W-1:0] pred);
      logic [LINK_W-1:0] cur;
      int unsigned       steps;
      cur   = chain_head[bucket_index(f, p)];
      pred  = NIL;
      steps = 0;
      while (cur < NIL && steps < BUFFERS) begin
         if (slot_file[cur[BUF_W-1:0]] == f && slot_page[cur[BUF_W-1:0]] == p) break;
         pred = cur;
         cur  = slot_next[cur[BUF_W-1:0]];
         steps++;
      end
      if (cur >= NIL || steps >= BUFFERS) cur = NIL;
      return cur;
   endfunction

   // Apply one transaction to the behavioral table and return its reply.
   function automatic bpt_rsp_type page_table_step(input bpt_req_type t);
      bpt_rsp_type       r;
      logic [LINK_W-1:0] owner;
      logic [LINK_W-1:0] pred;
      logic [BUF_W-1:0]  bid;
      int unsigned       h;
      r   = '0;
      bid = t.buffer_id;
      if (t.op == OP_FIND) begin
         owner = chain_search(t.key_file_id, t.key_page_num, pred);
         if (owner < NIL) begin
            r.hit          = 1'b1;
            r.found_buffer = owner[BUF_ID_W-1:0];
         end
      end else begin
         owner = NIL;
         pred  = NIL;
         if (!(t.old_file_id == '0 && t.old_page_num == no_page_code))
            owner = chain_search(t.old_file_id, t.old_page_num, pred);
         if (owner < NIL && owner != LINK_W'(t.buffer_id)) begin
            // old key belongs to another buffer: refuse, name the owner
            r.status       = STATUS_REFUSED;
            r.found_buffer = owner[BUF_ID_W-1:0];
         end else if (owner >= NIL && slot_mapped[bid]) begin
            // buffer would hold two pages: refuse
            r.status = STATUS_REFUSED;
         end else begin
            if (owner < NIL) begin
               if (pred < NIL)
                  slot_next[pred[BUF_W-1:0]] = slot_next[owner[BUF_W-1:0]];
               else
                  chain_head[bucket_index(t.old_file_id, t.old_page_num)] =
                     slot_next[owner[BUF_W-1:0]];
               slot_mapped[owner[BUF_W-1:0]] = 1'b0;
               r.hit          = 1'b1;
               r.found_buffer = owner[BUF_ID_W-1:0];
            end
            h              = bucket_index(t.key_file_id, t.key_page_num);
            slot_file[bid] = t.key_file_id;
            slot_page[bid] = t.key_page_num;
            slot_next[bid] = chain_head[h];
            chain_head[h]  = LINK_W'(bid);
            slot_mapped[bid] = 1'b1;
         end
      end
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation
   // ---------------------------------------------------------------------
   function automatic logic [PAGE_W-1:0] random_page();
      logic [PAGE_W-1:0] p;
      int unsigned       pick;
      pick = $urandom_range(0, 19);
      p    = $urandom();
      if (pick < 12) begin
         // land in a hot bucket; keep the upper bits few now and then
         p[BUCKET_W-1:0] = hot_bucket[$urandom_range(0, HOT_COUNT - 1)];
         if (pick < 4) p[PAGE_W-1:BUCKET_W] = (PAGE_W - BUCKET_W)'($urandom_range(0, 3));
      end else if (pick == 17) begin
         p = '0;
      end else if (pick == 18) begin
         p = '1;
      end else if (pick == 19) begin
         p = no_page_code;
      end
      return p;
   endfunction

   function automatic logic [FILE_W-1:0] random_file();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 6) return FILE_W'($urandom_range(0, 3));
      if (pick == 9) return '1;
      return FILE_W'($urandom());
   endfunction

   // probe a few buffer ids for one that holds a page; -1 if none found
   function automatic int find_mapped_slot();
      int id;
      for (int n = 0; n < 16; n++) begin
         id = $urandom_range(0, BUFFERS - 1);
         if (slot_mapped[id]) return id;
      end
      return -1;
   endfunction

   // mostly fresh keys, sometimes one already mapped, for hits and duplicates
   function automatic void pick_key(output logic [FILE_W-1:0] f,
                                    output logic [PAGE_W-1:0] p);
      int slot;
      slot = -1;
      if ($urandom_range(0, 3) == 0) slot = find_mapped_slot();
      if (slot >= 0) begin
         f = slot_file[slot];
         p = slot_page[slot];
      end else begin
         f = random_file();
         p = random_page();
      end
   endfunction

   function automatic bpt_req_type random_fields();
      bpt_req_type t;
      t.op           = 1'($urandom());
      t.key_file_id  = FILE_W'($urandom());
      t.key_page_num = PAGE_W'($urandom());
      t.old_file_id  = FILE_W'($urandom());
      t.old_page_num = PAGE_W'($urandom());
      t.buffer_id    = BUF_ID_W'($urandom());
      return t;
   endfunction

   function automatic bpt_req_type make_find();
      bpt_req_type       t;
      logic [FILE_W-1:0] f;
      logic [PAGE_W-1:0] p;
      int                slot;
      t    = random_fields();
      t.op = OP_FIND;
      slot = ($urandom_range(0, 4) < 3) ? find_mapped_slot() : -1;
      if (slot >= 0) begin
         f = slot_file[slot];
         p = slot_page[slot];
      end else begin
         pick_key(f, p);
      end
      t.key_file_id  = f;
      t.key_page_num = p;
      return t;
   endfunction

   // A well-formed remap names the buffer's real old key or, for an unmapped
   // buffer, mostly the no-old-page code; a spoiled one may break the rule.
   function automatic bpt_req_type make_remap(input bit well_formed);
      bpt_req_type       t;
      logic [FILE_W-1:0] f;
      logic [PAGE_W-1:0] p;
      int                slot;
      spoil_kind_type    spoil;
      t    = random_fields();
      t.op = OP_REMAP;
      slot = $urandom_range(0, 1) ? find_mapped_slot() : -1;
      if (slot >= 0) t.buffer_id = BUF_ID_W'(slot);
      pick_key(f, p);
      t.key_file_id  = f;
      t.key_page_num = p;
      if (well_formed) begin
         if (slot_mapped[t.buffer_id]) begin
            t.old_file_id  = slot_file[t.buffer_id];
            t.old_page_num = slot_page[t.buffer_id];
         end else if ($urandom_range(0, 3) != 0) begin
            t.old_file_id  = '0;
            t.old_page_num = no_page_code;
         end else begin
            t.old_file_id  = random_file();
            t.old_page_num = random_page();
         end
      end else begin
         spoil = spoil_kind_type'($urandom_range(0, 3));
         case (spoil)
            SPOIL_OTHER_OWNER: begin
               slot = find_mapped_slot();
               if (slot >= 0) begin
                  t.old_file_id  = slot_file[slot];
                  t.old_page_num = slot_page[slot];
               end
            end
            SPOIL_RANDOM_OLD: begin
               t.old_file_id  = random_file();
               t.old_page_num = random_page();
            end
            SPOIL_NO_PAGE: begin
               t.old_file_id  = '0;
               t.old_page_num = no_page_code;
            end
            default: begin
               t.old_file_id  = slot_file[t.buffer_id];
               t.old_page_num = slot_page[t.buffer_id];
               t.old_page_num[$urandom_range(0, PAGE_W - 1)] ^= 1'b1;
            end
         endcase
      end
      return t;
   endfunction

   // mostly short gaps, a few long ones, none in a burst
   function automatic int unsigned pick_gap();
      int unsigned pick;
      if (burst_mode) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 80);
   endfunction

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // Present one transaction and hold it until an edge with busy low takes
   // it; predict the reply right there. With a zero gap start stays high so
   // the next transaction follows back to back.
   task automatic issue_table_op(input bpt_req_type t, input int unsigned gap);
      bpt_rsp_type predicted;
      start    <= 1'b1;
      req_data <= t;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = page_table_step(t);
      lookup_results_q.push_back(predicted);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic run_op(input logic op,
                         input logic [FILE_W-1:0] kf, input logic [PAGE_W-1:0] kp,
                         input logic [FILE_W-1:0] of, input logic [PAGE_W-1:0] opg,
                         input logic [BUF_ID_W-1:0] bid);
      bpt_req_type t;
      t.op           = op;
      t.key_file_id  = kf;
      t.key_page_num = kp;
      t.old_file_id  = of;
      t.old_page_num = opg;
      t.buffer_id    = bid;
      issue_table_op(t, pick_gap());
   endtask

   // Drop start and hold off until every predicted reply has arrived, then
   // let the block settle.
   task automatic wait_idle();
      start <= 1'b0;
      while (lookup_results_q.size() != 0) @(posedge clock);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Write the register only with the block idle; the table model follows
   // at the same edge.
   task automatic write_invalid_code(input logic [PAGE_W-1:0] code);
      wait_idle();
      csr_we    <= 1'b1;
      csr_wdata <= code;
      @(posedge clock);
      no_page_code = code;
      csr_we <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Reply checker: every strobe must match the oldest prediction
   // ---------------------------------------------------------------------
   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : rsp_compare
      bpt_rsp_type want;
      if (!reset && rsp_valid) begin
         if (lookup_results_q.size() == 0) begin
            error_count++;
            $display("%0t: reply with none outstanding, expected none, actual %0d/%0d/%0d",
                     $time, rsp_data.hit, rsp_data.found_buffer, rsp_data.status);
         end else begin
            want = lookup_results_q.pop_front();
            check_field("hit", want.hit, rsp_data.hit);
            check_field("found_buffer", want.found_buffer, rsp_data.found_buffer);
            check_field("status", want.status, rsp_data.status);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: end a stuck run
   // ---------------------------------------------------------------------
   always @(posedge clock) cycle_count <= cycle_count + 1;

   initial begin
      wait (cycle_count >= LIMIT_CYCLES);
      $display("buffer_page_table verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Look up the extreme keys in the freshly cleared table.
   task automatic test_empty_lookups();
      run_op(OP_FIND, '0, '0, '0, '0, '0);
      run_op(OP_FIND, '1, '1, '1, '1, '1);
   endtask

   // Map the lowest and highest buffers with no old page, then find them.
   task automatic test_first_mappings();
      run_op(OP_REMAP, '0, '0, '0, NO_PAGE_AT_RESET, '0);
      run_op(OP_REMAP, '1, '1, '0, NO_PAGE_AT_RESET, '1);
      run_op(OP_FIND, '0, '0, '1, '1, '1);
      run_op(OP_FIND, '1, '1, '0, '0, '0);
   endtask

   // Stack a duplicate key and a same-bucket key with another file id on
   // bucket 0; the newest mapping must win and file ids must be compared.
   task automatic test_chain_order();
      run_op(OP_REMAP, '0, '0, '0, NO_PAGE_AT_RESET, 10'd5);
      run_op(OP_FIND, '0, '0, '0, '0, '0);
      run_op(OP_REMAP, 16'd1, '0, '0, NO_PAGE_AT_RESET, 10'd6);
      run_op(OP_FIND, 16'd1, '0, '0, '0, '0);
      run_op(OP_FIND, 16'd2, '0, '0, '0, '0);
   endtask

   // Refuse: old key owned by another buffer, no old page on a mapped
   // buffer, and an absent old key on a mapped buffer.
   task automatic test_refusals();
      run_op(OP_REMAP, 16'd9, 32'd9, '0, '0, '0);
      run_op(OP_REMAP, 16'd9, 32'd9, '0, NO_PAGE_AT_RESET, '0);
      run_op(OP_REMAP, 16'd9, 32'd9, 16'd7, 32'd7, '0);
   endtask

   // Unlink from the middle of a chain twice and then from the tail of a chain,
   // and remap an unmapped buffer whose named old key is absent.
   task automatic test_unlink();
      run_op(OP_REMAP, 16'd3, 32'h400, '0, '0, 10'd5);
      run_op(OP_FIND, '0, '0, '0, '0, '0);
      run_op(OP_REMAP, '1, 32'h3FF, 16'd1, '0, 10'd6);
      run_op(OP_REMAP, '0, 32'd1, '1, '1, '1);
      run_op(OP_REMAP, 16'd7, 32'd7, 16'd7, 32'd7, 10'd2);
      run_op(OP_FIND, 16'd7, 32'd7, '0, '0, '0);
   endtask

   // Move the no-old-page code to page 0: file 0 page 0 then means no old
   // page even though buffer 0 maps it, and all-ones becomes a real key.
   task automatic test_no_page_code();
      write_invalid_code('0);
      run_op(OP_REMAP, 16'd4, 32'd4, '0, '0, 10'd3);
      run_op(OP_FIND, 16'd4, 32'd4, '0, '0, '0);
      run_op(OP_REMAP, 16'd8, 32'd8, '0, '1, 10'd4);
      write_invalid_code(NO_PAGE_AT_RESET);
   endtask

   // Mostly finds and well-formed remaps with random content, some spoiled
   // remaps; drain once midway and at random points.
   task automatic test_random_traffic(input int unsigned count,
                                      input logic [PAGE_W-1:0] code);
      int unsigned mix;
      bpt_req_type t;
      write_invalid_code(code);
      for (int unsigned n = 0; n < count; n++) begin
         if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
         if (n == count / 2 || $urandom_range(0, 199) == 0) wait_idle();
         mix = $urandom_range(0, 99);
         if (mix < 40)      t = make_find();
         else if (mix < 85) t = make_remap(1'b1);
         else               t = make_remap(1'b0);
         issue_table_op(t, pick_gap());
      end
      burst_mode = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      for (int i = 0; i < HOT_COUNT; i++) hot_bucket[i] = BUCKET_W'($urandom());
      hot_bucket[0] = '0;
      hot_bucket[1] = '1;
      clear_table_model();

      // hold reset, then release; the block clears itself with busy high
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_empty_lookups();
      test_first_mappings();
      test_chain_order();
      test_refusals();
      test_unlink();
      test_no_page_code();

      test_random_traffic(400, NO_PAGE_AT_RESET);
      test_random_traffic(400, '0);
      test_random_traffic(350, PAGE_W'($urandom()));
      test_random_traffic(400, {PAGE_W'($urandom()) & ~PAGE_W'(BUCKETS - 1)}
                               | PAGE_W'(hot_bucket[2]));

      // drain, then leave room for any stray reply
      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && lookup_results_q.size() == 0)
         $display("buffer_page_table verification clean");
      else
         $display("buffer_page_table verification failed");
      $finish;
   end

endmodule
